>>> sv/shbl_pkg.sv
`default_nettype none

package shbl_pkg;

  localparam int unsigned CfgW        = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned HeatW       = 32;
  localparam int unsigned TickW       = 32;
  localparam int unsigned MilliW      = 26;
  localparam int unsigned InDataW     = 88;
  localparam int unsigned InUserW     = 2;
  localparam int unsigned OutDataW    = 96;

  localparam int unsigned Milli          = 1000;
  localparam int unsigned SafetyReserve  = 15;
  localparam int unsigned FifoDepthDef   = 4;

  localparam logic [CfgW-1:0] RstProjHeat  = 16'd100;
  localparam logic [CfgW-1:0] RstDefLimit  = 16'd20000;
  localparam logic [CfgW-1:0] RstDefCool   = 16'd2000;
  localparam logic [CfgW-1:0] RstStartHeat = 16'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROJ_HEAT  = 2'd0,
    REG_DEF_LIMIT  = 2'd1,
    REG_DEF_COOL   = 2'd2,
    REG_START_HEAT = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_REINIT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_SHOT   = 2'd2,
    OP_CHECK  = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              sample_ok;
    logic              frame;
    logic              bypass;
    logic [CfgW-1:0]   rate;
    logic [CfgW-1:0]   limit;
    logic [MilliW-1:0] heat_milli;
    logic [TickW-1:0]  now;
  } item_t;

  typedef struct packed {
    logic                 we;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgW-1:0]      data;
  } cfg_wr_t;

  function automatic logic [MilliW-1:0] to_milli(input logic [CfgW-1:0] x);
    to_milli = MilliW'(x) * MilliW'(Milli);
  endfunction

endpackage

`default_nettype wire

>>> sv/shot_heat_budget_limiter.sv
// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid tready tuser tdata     action; referee sample, time, bypass
// m_axis    out  tvalid tready tdata           verdict, heat, remaining, limits, flags
// cfg       in   cfg_we_i cfg_idx_i cfg_data_i register write, no read-back
//
// One transaction per cycle sustained in both directions while m_axis_tready stays high;
// input reaches output through the queue and then the result register.
// The execute stage updates heat combinationally: one 16x32 cooling multiply,
// compare and subtract, then the admission add and compare.
// rst_ni empties the queue, drops the result valid and returns state and configuration to reset values at once.
// A stall on m_axis fills the queue; s_axis_tready drops only when it is full.
`default_nettype none

module shot_heat_budget_limiter #(
  parameter int unsigned FIFO_DEPTH = shbl_pkg::FifoDepthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [1:0] action
  input  wire logic [shbl_pkg::InUserW-1:0]      s_axis_tuser,
  // [0] link_online, [1] frame_received, [17:2] rate_in, [33:18] limit_in,
  // [49:34] heat_in, [81:50] now_ms, [82] bypass, [87:83] zero
  input  wire logic [shbl_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] allowed, [32:1] heat_milli, [58:33] remaining_milli, [74:59] limit_now,
  // [90:75] cooling_now, [91] online_flag, [92] received_flag, [93] config_ok,
  // [95:94] zero
  output logic [shbl_pkg::OutDataW-1:0]          m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [shbl_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [shbl_pkg::CfgW-1:0]         cfg_data_i
);

  logic              q_push, q_ready, q_valid, q_pop;
  shbl_pkg::item_t   item_in, item_out;
  shbl_pkg::cfg_wr_t cfg_wr;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_data_i;
  assign s_axis_tready = q_ready;

  shbl_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_item_o      (item_in)
  );

  shbl_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (item_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (item_out)
  );

  shbl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_wr),
    .q_valid_i     (q_valid),
    .q_item_i      (item_out),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> sv/shbl_front.sv
`default_nettype none

module shbl_front (
  input  wire logic                              s_axis_tvalid,
  input  wire logic [shbl_pkg::InUserW-1:0]      s_axis_tuser,
  input  wire logic [shbl_pkg::InDataW-1:0]      s_axis_tdata,
  input  wire logic                              q_ready_i,
  output logic                                   q_push_o,
  output shbl_pkg::item_t                        q_item_o
);

  logic [shbl_pkg::CfgW-1:0] rate, limit, heat;

  assign rate  = s_axis_tdata[17:2];
  assign limit = s_axis_tdata[33:18];
  assign heat  = s_axis_tdata[49:34];

  always_comb begin
    q_item_o.op         = shbl_pkg::op_e'(s_axis_tuser);
    q_item_o.frame      = s_axis_tdata[1];
    q_item_o.sample_ok  = s_axis_tdata[0] && s_axis_tdata[1] &&
                          (limit != '0) && (heat <= limit);
    q_item_o.bypass     = s_axis_tdata[82];
    q_item_o.rate       = rate;
    q_item_o.limit      = limit;
    q_item_o.heat_milli = shbl_pkg::to_milli(heat);
    q_item_o.now        = s_axis_tdata[81:50];
  end

  assign q_push_o = s_axis_tvalid && q_ready_i;

endmodule

`default_nettype wire

>>> sv/shbl_fifo.sv
`default_nettype none

module shbl_fifo #(
  parameter int unsigned DEPTH = shbl_pkg::FifoDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire shbl_pkg::item_t  item_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output shbl_pkg::item_t       item_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  shbl_pkg::item_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/shbl_back.sv
`default_nettype none

module shbl_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire shbl_pkg::cfg_wr_t             cfg_i,
  input  wire logic                          q_valid_i,
  input  wire shbl_pkg::item_t               q_item_i,
  output logic                               q_pop_o,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [shbl_pkg::OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned HW = shbl_pkg::HeatW;
  localparam int unsigned CW = shbl_pkg::CfgW;
  localparam int unsigned MW = shbl_pkg::MilliW;
  localparam int unsigned SumW = HW + 2;
  localparam logic [SumW-1:0] ResMilli = SumW'(shbl_pkg::SafetyReserve * shbl_pkg::Milli);
  localparam logic ValidRst = (shbl_pkg::RstProjHeat != '0) && (shbl_pkg::RstDefLimit != '0);

  logic [CW-1:0] proj_q, dlim_q, dcool_q, start_q;

  logic [HW-1:0] heat_q, heat_d;
  logic [CW-1:0] limit_q, limit_d, cool_q, cool_d;
  logic [shbl_pkg::TickW-1:0] tick_q, tick_d;
  logic online_q, online_d, recv_q, recv_d, valid_q, valid_d;

  logic                       out_valid_q;
  logic [shbl_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic [shbl_pkg::TickW-1:0] elapsed;
  logic [CW+HW-1:0]           drop;
  logic [HW-1:0]              heat_cool, adm_heat;
  logic [MW-1:0]              proj_milli, lim_milli, lim_milli_d;
  logic [SumW-1:0]            need, shot_sum;
  logic                       cfg_ok, admit, sample, allowed;
  logic [MW-1:0]              remaining;

  assign q_pop_o = q_valid_i && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_q  <= shbl_pkg::RstProjHeat;
      dlim_q  <= shbl_pkg::RstDefLimit;
      dcool_q <= shbl_pkg::RstDefCool;
      start_q <= shbl_pkg::RstStartHeat;
    end else if (cfg_i.we) begin
      case (shbl_pkg::reg_idx_e'(cfg_i.idx))
        shbl_pkg::REG_PROJ_HEAT:  proj_q  <= cfg_i.data;
        shbl_pkg::REG_DEF_LIMIT:  dlim_q  <= cfg_i.data;
        shbl_pkg::REG_DEF_COOL:   dcool_q <= cfg_i.data;
        shbl_pkg::REG_START_HEAT: start_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    elapsed    = q_item_i.now - tick_q;
    drop       = (CW + HW)'(cool_q) * (CW + HW)'(elapsed);
    if (tick_q == '0) begin
      heat_cool = heat_q;
    end else if (drop >= (CW + HW)'(heat_q)) begin
      heat_cool = '0;
    end else begin
      heat_cool = heat_q - drop[HW-1:0];
    end

    cfg_ok     = (proj_q != '0) && (dlim_q != '0);
    proj_milli = shbl_pkg::to_milli(proj_q);
    lim_milli  = shbl_pkg::to_milli(limit_q);

    adm_heat = (q_item_i.op == shbl_pkg::OP_SHOT) ? heat_cool : heat_q;
    need     = SumW'(adm_heat) + SumW'(proj_milli) + ResMilli;
    admit    = valid_q && (q_item_i.bypass ||
               ((SumW'(lim_milli) > ResMilli) && (need <= SumW'(lim_milli))));
    shot_sum = SumW'(heat_cool) + SumW'(proj_milli);
    sample   = cfg_ok && q_item_i.sample_ok;

    heat_d   = heat_q;
    limit_d  = limit_q;
    cool_d   = cool_q;
    tick_d   = tick_q;
    online_d = online_q;
    recv_d   = recv_q;
    valid_d  = valid_q;
    allowed  = 1'b0;

    case (q_item_i.op)
      shbl_pkg::OP_REINIT: begin
        valid_d  = cfg_ok;
        online_d = 1'b0;
        recv_d   = 1'b0;
        heat_d   = HW'(shbl_pkg::to_milli(start_q));
        limit_d  = dlim_q;
        cool_d   = dcool_q;
        tick_d   = '0;
      end
      shbl_pkg::OP_UPDATE: begin
        valid_d  = cfg_ok;
        recv_d   = q_item_i.frame;
        online_d = sample;
        tick_d   = q_item_i.now;
        if (sample) begin
          limit_d = q_item_i.limit;
          cool_d  = q_item_i.rate;
          heat_d  = HW'(q_item_i.heat_milli);
        end else begin
          heat_d = heat_cool;
          if (limit_q == '0) begin
            limit_d = dlim_q;
          end
        end
      end
      shbl_pkg::OP_SHOT: begin
        tick_d = q_item_i.now;
        heat_d = heat_cool;
        if (admit) begin
          allowed = 1'b1;
          heat_d  = (shot_sum[SumW-1:HW] != '0) ? '1 : shot_sum[HW-1:0];
        end
      end
      shbl_pkg::OP_CHECK: begin
        allowed = admit;
      end
      default: ;
    endcase

    lim_milli_d = shbl_pkg::to_milli(limit_d);
    remaining   = (HW'(lim_milli_d) > heat_d) ? MW'(HW'(lim_milli_d) - heat_d) : '0;

    out_data_d = {2'b00, valid_d, recv_d, online_d, cool_d, limit_d, remaining,
                  heat_d, allowed};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_q      <= HW'(shbl_pkg::to_milli(shbl_pkg::RstStartHeat));
      limit_q     <= shbl_pkg::RstDefLimit;
      cool_q      <= shbl_pkg::RstDefCool;
      tick_q      <= '0;
      online_q    <= 1'b0;
      recv_q      <= 1'b0;
      valid_q     <= ValidRst;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        heat_q   <= heat_d;
        limit_q  <= limit_d;
        cool_q   <= cool_d;
        tick_q   <= tick_d;
        online_q <= online_d;
        recv_q   <= recv_d;
        valid_q  <= valid_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> sv/shbl_chk.sv
`default_nettype none

module shbl_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [shbl_pkg::InUserW-1:0]      s_axis_tuser,
  input wire logic [shbl_pkg::InDataW-1:0]      s_axis_tdata,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [shbl_pkg::OutDataW-1:0]     m_axis_tdata,
  input wire logic                              cfg_we_i,
  input wire logic [shbl_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input wire logic [shbl_pkg::CfgW-1:0]         cfg_data_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_allow_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[93])
    else $error("shot allowed with invalid configuration");

  a_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[91] |-> m_axis_tdata[92] && m_axis_tdata[93])
    else $error("online sample without frame or valid configuration");

  a_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ({1'b0, m_axis_tdata[58:33]} <= (27'(m_axis_tdata[74:59]) * 27'd1000)))
    else $error("remaining exceeds limit");

endmodule

bind shot_heat_budget_limiter shbl_chk u_shbl_chk (.*);

`default_nettype wire
